// ===== rtl/core/spgq_pkg.sv =====
// Package for the short-press gate qualifier: phase codes, register indexes,
// register reset values and the structs passed between the core modules.
// No dependencies.
`timescale 1ns / 1ps

package spgq_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 2;

    typedef logic [1:0]        t_phase;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [CFG_W-1:0]  t_cfg_val;
    typedef logic [IDX_W-1:0]  t_cfg_idx;

    // Phase codes
    localparam t_phase PH_IDLE     = 2'd0;
    localparam t_phase PH_PRESSING = 2'd1;
    localparam t_phase PH_AWAIT    = 2'd2;
    localparam t_phase PH_OPEN     = 2'd3;

    // Register indexes
    localparam t_cfg_idx REG_DEBOUNCE  = 2'd0;
    localparam t_cfg_idx REG_MIN_PRESS = 2'd1;
    localparam t_cfg_idx REG_MAX_PRESS = 2'd2;

    // Register reset values (ms)
    localparam t_cfg_val RST_DEBOUNCE  = 16'd25;
    localparam t_cfg_val RST_MIN_PRESS = 16'd20;
    localparam t_cfg_val RST_MAX_PRESS = 16'd1200;

    typedef struct packed {
        t_cfg_val debounce_time;
        t_cfg_val min_press_time;
        t_cfg_val max_press_time;
    } t_cfg;

    typedef struct packed {
        t_time now_time;
        logic  button_down;
        logic  force_open;
    } t_sample;

endpackage

// ===== rtl/core/spgq_if.sv =====
// Handshake channel interfaces for the short-press gate qualifier:
// sample input, result output and configuration write.
// Depends on spgq_pkg.
`timescale 1ns / 1ps

interface spgq_in_if;
    logic                valid;
    logic                ready;
    spgq_pkg::t_time     now_time;
    logic                button_down;
    logic                force_open;

    modport source (output valid, output now_time, output button_down,
                    output force_open, input ready);
    modport sink   (input valid, input now_time, input button_down,
                    input force_open, output ready);
endinterface

interface spgq_out_if;
    logic                valid;
    logic                ready;
    logic                gate_open;
    spgq_pkg::t_phase    phase;

    modport source (output valid, output gate_open, output phase, input ready);
    modport sink   (input valid, input gate_open, input phase, output ready);
endinterface

interface spgq_cfg_if;
    logic                valid;
    logic                ready;
    spgq_pkg::t_cfg_idx  index;
    spgq_pkg::t_cfg_val  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/spgq_cfg_regs.sv =====
// Configuration register file: debounce, minimum and maximum press time.
// Depends on spgq_pkg.
`timescale 1ns / 1ps

module spgq_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  spgq_pkg::t_cfg_idx i_wr_idx,
    input  spgq_pkg::t_cfg_val i_wr_data,
    output spgq_pkg::t_cfg     o_cfg
);

    spgq_pkg::t_cfg r_cfg;
    spgq_pkg::t_cfg n_cfg;

    // Decode the write; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_idx)
                spgq_pkg::REG_DEBOUNCE:  n_cfg.debounce_time  = i_wr_data;
                spgq_pkg::REG_MIN_PRESS: n_cfg.min_press_time = i_wr_data;
                spgq_pkg::REG_MAX_PRESS: n_cfg.max_press_time = i_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time  <= spgq_pkg::RST_DEBOUNCE;
            r_cfg.min_press_time <= spgq_pkg::RST_MIN_PRESS;
            r_cfg.max_press_time <= spgq_pkg::RST_MAX_PRESS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/spgq_in_stage.sv =====
// Input register stage: captures one sample beat and holds it until the
// qualifier takes it. Depends on spgq_pkg.
`timescale 1ns / 1ps

module spgq_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  spgq_pkg::t_sample i_smp,
    output logic              o_valid,
    input  logic              i_ready,
    output spgq_pkg::t_sample o_smp
);

    logic              r_valid;
    spgq_pkg::t_sample r_smp;
    logic              w_load;

    // Accept a new beat when empty or when the held one moves on this cycle
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_smp <= i_smp;
        end
    end

    assign o_valid = r_valid;
    assign o_smp   = r_smp;

endmodule

// ===== rtl/core/spgq_qual.sv =====
// Press qualifier: applies one registered sample to the press state and
// registers the result beat. Depends on spgq_pkg.
`timescale 1ns / 1ps

module spgq_qual (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spgq_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  spgq_pkg::t_sample i_smp,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_gate_open,
    output spgq_pkg::t_phase  o_phase
);

    // Press state
    spgq_pkg::t_phase r_phase, n_phase;
    logic             r_started, n_started;
    logic             r_open, n_open;
    logic             r_prev, n_prev;
    spgq_pkg::t_time  r_edge, n_edge;
    spgq_pkg::t_time  r_press, n_press;
    spgq_pkg::t_time  r_rel, n_rel;

    // Result register
    logic             r_out_valid;
    logic             r_out_gate;
    spgq_pkg::t_phase r_out_phase;

    logic             w_step;
    spgq_pkg::t_time  w_held;
    spgq_pkg::t_time  w_since_rel;
    spgq_pkg::t_time  w_since_edge;
    spgq_pkg::t_time  w_max;
    spgq_pkg::t_time  w_min;
    spgq_pkg::t_time  w_deb;

    assign o_ready = !r_out_valid || i_ready;
    assign w_step  = i_valid && o_ready;

    assign w_max = {16'd0, i_cfg.max_press_time};
    assign w_min = {16'd0, i_cfg.min_press_time};
    assign w_deb = {16'd0, i_cfg.debounce_time};

    // Next press state for the sample at the head of the input stage
    always_comb begin
        n_phase   = r_phase;
        n_started = r_started;
        n_open    = r_open;
        n_prev    = r_prev;
        n_edge    = r_edge;
        n_press   = r_press;
        n_rel     = r_rel;
        w_held       = '0;
        w_since_rel  = '0;
        w_since_edge = '0;
        if (i_smp.force_open) begin
            n_open    = 1'b1;
            n_phase   = spgq_pkg::PH_OPEN;
            n_started = 1'b1;
        end else if (!r_open && (r_phase != spgq_pkg::PH_OPEN)) begin
            // First sample seeds level and time
            if (!r_started) begin
                n_prev = i_smp.button_down;
                n_edge = i_smp.now_time;
                if (i_smp.button_down) begin
                    n_phase = spgq_pkg::PH_PRESSING;
                    n_press = i_smp.now_time;
                end
                n_started = 1'b1;
            end
            // Track raw edges
            if (i_smp.button_down != n_prev) begin
                n_prev = i_smp.button_down;
                n_edge = i_smp.now_time;
            end
            w_held       = i_smp.now_time - n_press;
            w_since_rel  = i_smp.now_time - n_rel;
            w_since_edge = i_smp.now_time - n_edge;
            unique case (n_phase)
                spgq_pkg::PH_IDLE: begin
                    if (i_smp.button_down) begin
                        n_phase = spgq_pkg::PH_PRESSING;
                        n_press = i_smp.now_time;
                    end
                end
                spgq_pkg::PH_PRESSING: begin
                    if (i_smp.button_down) begin
                        if (w_held > w_max) begin
                            n_phase = spgq_pkg::PH_IDLE;
                        end
                    end else if (w_held >= w_min && w_held <= w_max) begin
                        n_phase = spgq_pkg::PH_AWAIT;
                        n_rel   = i_smp.now_time;
                    end else begin
                        n_phase = spgq_pkg::PH_IDLE;
                    end
                end
                spgq_pkg::PH_AWAIT: begin
                    if (i_smp.button_down) begin
                        n_phase = spgq_pkg::PH_PRESSING;
                        n_press = i_smp.now_time;
                    end else if (w_since_rel >= w_deb && w_since_edge >= w_deb) begin
                        n_open  = 1'b1;
                        n_phase = spgq_pkg::PH_OPEN;
                    end
                end
                default: ;
            endcase
        end
    end

    // Commit state on each stepped beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= spgq_pkg::PH_IDLE;
            r_started <= 1'b0;
            r_open    <= 1'b0;
            r_prev    <= 1'b0;
            r_edge    <= '0;
            r_press   <= '0;
            r_rel     <= '0;
        end else if (w_step) begin
            r_phase   <= n_phase;
            r_started <= n_started;
            r_open    <= n_open;
            r_prev    <= n_prev;
            r_edge    <= n_edge;
            r_press   <= n_press;
            r_rel     <= n_rel;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_gate  <= n_open;
            r_out_phase <= n_phase;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_gate_open = r_out_gate;
    assign o_phase     = r_out_phase;

endmodule

// ===== rtl/core/short_press_gate_qualifier.sv =====
// Top level of the short-press gate qualifier: configuration registers,
// input register stage and press qualifier. Depends on spgq_pkg, spgq_if.
//
// Usage:
//   i_in  : sample beats (now_time in ms, raw button_down, force_open).
//   o_res : one result beat per sample (gate_open latch, phase code).
//   i_cfg : register writes; index 0 debounce, 1 min press, 2 max press,
//           other indexes are dropped. Always ready; write only while idle.
// Pipeline: a sample taken on i_in passes the input register, then the
//   result register (two register stages) before o_res shows its result.
// Throughput: one sample per cycle while o_res is taken; the qualifier
//   state update is 32-bit subtractions and compares, all combinational.
// Reset (synchronous, active low): phase idle, gate closed, timestamps zero,
//   registers back to 25 / 20 / 1200 ms, no beats held.
// Stall: while o_res is not taken, the result and the held sample stay put
//   and i_in.ready drops once both stages are full.
`timescale 1ns / 1ps

module short_press_gate_qualifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spgq_in_if.sink    i_in,
    spgq_out_if.source o_res,
    spgq_cfg_if.sink   i_cfg
);

    spgq_pkg::t_cfg    w_cfg;
    spgq_pkg::t_sample w_in_smp;
    spgq_pkg::t_sample w_q_smp;
    logic              w_q_valid;
    logic              w_q_ready;

    // Configuration channel never stalls
    assign i_cfg.ready = 1'b1;

    spgq_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_idx  (i_cfg.index),
        .i_wr_data (i_cfg.data),
        .o_cfg     (w_cfg)
    );

    assign w_in_smp.now_time    = i_in.now_time;
    assign w_in_smp.button_down = i_in.button_down;
    assign w_in_smp.force_open  = i_in.force_open;

    spgq_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_smp   (w_in_smp),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_smp   (w_q_smp)
    );

    spgq_qual u_qual (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_q_valid),
        .o_ready     (w_q_ready),
        .i_smp       (w_q_smp),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_gate_open (o_res.gate_open),
        .o_phase     (o_res.phase)
    );

endmodule
